// ===== sv/mrpt_pkg.sv =====
// Package for the Miller-Rabin primality tester.
// Shared types, constants and controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package mrpt_pkg;

   localparam int unsigned NumSmall = 12;
   localparam int unsigned NumBase  = 7;

   localparam logic [5:0] SMALL_PRIMES [NumSmall] = '{
      6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
   };

   localparam logic [30:0] MR_BASES [NumBase] = '{
      31'd2, 31'd325, 31'd9375, 31'd28178, 31'd450775, 31'd9780504, 31'd1795265022
   };

   // modular multiply operand/destination select
   typedef enum logic [1:0] {
      MUL_RED = 2'd0,   // 1 * base -> b   (base mod n)
      MUL_XB  = 2'd1,   // x * b    -> x
      MUL_BB  = 2'd2,   // b * b    -> b
      MUL_XX  = 2'd3    // x * x    -> x
   } mul_op_type;

   typedef struct packed {
      logic       load;
      logic       trial_step;
      logic       mul_start;
      mul_op_type mul_op;
      logic       init_pow;
      logic       shift_e;
      logic       sq_init;
      logic       sq_inc;
      logic       base_inc;
   } cmd_type;

   typedef struct packed {
      logic n_invalid;
      logic trial_last;
      logic small_hit;
      logic small_prime;
      logic mul_busy;
      logic b_zero;
      logic e_zero;
      logic e_lsb;
      logic x_one;
      logic x_nm1;
      logic sq_end;
      logic base_last;
   } status_type;

endpackage
`default_nettype wire

// ===== sv/mrpt_req_if.sv =====
// Request channel: valid/ready handshake carrying the number to test.
// Depends on nothing.
`default_nettype none
interface mrpt_req_if;
   logic               valid;
   logic               ready;
   logic signed [63:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface
`default_nettype wire

// ===== sv/mrpt_rsp_if.sv =====
// Response channel: valid/ready handshake carrying the prime flag.
// Depends on nothing.
`default_nettype none
interface mrpt_rsp_if;
   logic valid;
   logic ready;
   logic prime_flag;

   modport source (output valid, output prime_flag, input ready);
   modport sink   (input valid, input prime_flag, output ready);
endinterface
`default_nettype wire

// ===== sv/miller_rabin_primality_test.sv =====
// Deterministic Miller-Rabin primality tester for signed 64-bit numbers.
// Uses mrpt_pkg, mrpt_req_if, mrpt_rsp_if, mrpt_ctrl and mrpt_datapath.
//
// Usage:
//  - req: one request carries a signed 64-bit number. It is taken when
//    req.valid and req.ready are both high; ready is high only while the
//    engine is idle (one request in flight at a time).
//  - rsp: one response per request, prime_flag = 1 when the number is prime.
//    The flag sits in an output register, so the engine goes back to idle
//    and takes the next request while an earlier response is still waiting.
//  - Numbers below 2 are answered without trial division. When one of the
//    primes 2..37 divides the number, radix-16 trial division settles it;
//    otherwise each of the seven bases adds a base reduction mod n, a modular
//    exponentiation by d and up to s-1 squarings. Cost is set by the
//    bit-serial modular multiplier, one shared unit for every product.
//  - Throughput: the next request is taken the cycle after the result has
//    moved into the output register.
//  - Reset: synchronous, active high; returns to idle with no response
//    pending. No clearing pass.
//  - Stall: a response not taken holds; a finished second result waits in
//    the engine until the output register frees up, and req.ready stays low.
`default_nettype none
module miller_rabin_primality_test
   import mrpt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   mrpt_req_if.sink  req,
   mrpt_rsp_if.source rsp
);

   cmd_type    cmd;
   status_type sts;

   // sequencer: handshakes, state machine, result register
   mrpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .rsp_flag  (rsp.prime_flag),
      .sts       (sts),
      .cmd       (cmd)
   );

   // operands, trial remainders and the modular multiplier
   mrpt_datapath u_dp (
      .clock  (clock),
      .reset  (reset),
      .number (req.number),
      .cmd    (cmd),
      .sts    (sts)
   );

   // multiplier start only from an idle unit
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !sts.mul_busy)
      else $error("multiplier started while busy");

   // a started product keeps the unit busy on the next cycle
   a_mul_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |=> sts.mul_busy)
      else $error("multiplier did not go busy");

   // a response never appears the cycle right after a request is taken
   a_min_lat: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !$rose(rsp.valid))
      else $error("response too early");

endmodule
`default_nettype wire

// ===== sv/mrpt_datapath.sv =====
// Datapath: operand registers, radix-16 trial division, n-1 = d*2^s split
// and a bit-serial modular multiplier. Depends on mrpt_pkg.
`default_nettype none
module mrpt_datapath
   import mrpt_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [63:0] number,
   input  wire cmd_type     cmd,
   output status_type       sts
);

   logic [63:0] n_ff, n_in;
   logic [63:0] d_ff, d_in;
   logic [5:0]  s_ff, s_in;
   logic [63:0] e_ff, e_in;
   logic [63:0] b_ff, b_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] r_ff, r_in;
   logic [63:0] mx_ff, mx_in;
   logic [63:0] y_ff, y_in;
   logic [3:0]  tcnt_ff, tcnt_in;
   logic [5:0]  mcnt_ff, mcnt_in;
   logic [5:0]  sq_ff, sq_in;
   logic [2:0]  bidx_ff, bidx_in;
   logic        busy_ff, busy_in;
   mul_op_type  op_ff, op_in;
   logic [5:0]  rem_ff [NumSmall];
   logic [5:0]  rem_in [NumSmall];

   logic [63:0] r_dbl, r_nxt, n_m1;
   logic [9:0]  rt, pk;
   logic        hit, hit_eq;

   // (a + b) mod m for a, b < m < 2^63
   function automatic logic [63:0] add_mod(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] m);
      logic [63:0] t;
      t = a + b;
      return (t >= m) ? t - m : t;
   endfunction

   assign r_dbl = add_mod(r_ff, r_ff, n_ff);
   assign r_nxt = y_ff[63] ? add_mod(r_dbl, mx_ff, n_ff) : r_dbl;
   assign n_m1  = n_ff - 64'd1;

   always_comb begin
      n_in    = n_ff;
      d_in    = d_ff;
      s_in    = s_ff;
      e_in    = e_ff;
      b_in    = b_ff;
      x_in    = x_ff;
      r_in    = r_ff;
      mx_in   = mx_ff;
      y_in    = y_ff;
      tcnt_in = tcnt_ff;
      mcnt_in = mcnt_ff;
      sq_in   = sq_ff;
      bidx_in = bidx_ff;
      busy_in = busy_ff;
      op_in   = op_ff;
      rt      = 10'd0;
      pk      = 10'd0;
      for (int i = 0; i < NumSmall; i++) rem_in[i] = rem_ff[i];

      if (cmd.load) begin
         n_in    = number;
         d_in    = number - 64'd1;
         s_in    = 6'd0;
         tcnt_in = 4'd15;
         bidx_in = 3'd0;
         for (int i = 0; i < NumSmall; i++) rem_in[i] = 6'd0;
      end

      // one dividend nibble per cycle, MSB first: rem*16 + nibble < 16p,
      // brought below p by subtracting 8p, 4p, 2p, p where they fit.
      // Strip up to four trailing zeros of d per cycle.
      if (cmd.trial_step) begin
         for (int i = 0; i < NumSmall; i++) begin
            rt = {rem_ff[i], n_ff[{tcnt_ff, 2'b00} +: 4]};
            for (int k = 3; k >= 0; k--) begin
               pk = 10'(SMALL_PRIMES[i]) << k;
               if (rt >= pk) rt = rt - pk;
            end
            rem_in[i] = rt[5:0];
         end
         tcnt_in = tcnt_ff - 4'd1;
         if (d_ff != 64'd0) begin
            if (d_ff[3:0] == 4'd0) begin
               d_in = d_ff >> 4;
               s_in = s_ff + 6'd4;
            end else if (d_ff[2:0] == 3'd0) begin
               d_in = d_ff >> 3;
               s_in = s_ff + 6'd3;
            end else if (d_ff[1:0] == 2'd0) begin
               d_in = d_ff >> 2;
               s_in = s_ff + 6'd2;
            end else if (!d_ff[0]) begin
               d_in = d_ff >> 1;
               s_in = s_ff + 6'd1;
            end
         end
      end

      if (cmd.init_pow) begin
         x_in = 64'd1;
         e_in = d_ff;
      end
      if (cmd.shift_e)  e_in = e_ff >> 1;
      if (cmd.sq_init)  sq_in = 6'd1;
      if (cmd.sq_inc)   sq_in = sq_ff + 6'd1;
      if (cmd.base_inc) bidx_in = bidx_ff + 3'd1;

      if (cmd.mul_start) begin
         busy_in = 1'b1;
         op_in   = cmd.mul_op;
         r_in    = 64'd0;
         mcnt_in = 6'd63;
         case (cmd.mul_op)
            MUL_RED: begin mx_in = 64'd1; y_in = {33'd0, MR_BASES[bidx_ff]}; end
            MUL_XB:  begin mx_in = x_ff;  y_in = b_ff; end
            MUL_BB:  begin mx_in = b_ff;  y_in = b_ff; end
            MUL_XX:  begin mx_in = x_ff;  y_in = x_ff; end
            default: begin mx_in = x_ff;  y_in = x_ff; end
         endcase
      end else if (busy_ff) begin
         r_in    = r_nxt;
         y_in    = y_ff << 1;
         mcnt_in = mcnt_ff - 6'd1;
         if (mcnt_ff == 6'd0) begin
            busy_in = 1'b0;
            case (op_ff)
               MUL_RED, MUL_BB: b_in = r_nxt;
               MUL_XB,  MUL_XX: x_in = r_nxt;
               default:         x_in = r_nxt;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      n_ff    <= n_in;
      d_ff    <= d_in;
      s_ff    <= s_in;
      e_ff    <= e_in;
      b_ff    <= b_in;
      x_ff    <= x_in;
      r_ff    <= r_in;
      mx_ff   <= mx_in;
      y_ff    <= y_in;
      tcnt_ff <= tcnt_in;
      mcnt_ff <= mcnt_in;
      sq_ff   <= sq_in;
      bidx_ff <= bidx_in;
      op_ff   <= op_in;
      for (int i = 0; i < NumSmall; i++) rem_ff[i] <= rem_in[i];
   end

   always_comb begin
      hit    = 1'b0;
      hit_eq = 1'b0;
      for (int i = 0; i < NumSmall; i++) begin
         if (rem_ff[i] == 6'd0) begin
            hit = 1'b1;
            if (n_ff == {58'd0, SMALL_PRIMES[i]}) hit_eq = 1'b1;
         end
      end
   end

   assign sts.n_invalid   = n_ff[63] || (n_ff < 64'd2);
   assign sts.trial_last  = (tcnt_ff == 4'd0);
   assign sts.small_hit   = hit;
   assign sts.small_prime = hit_eq;
   assign sts.mul_busy    = busy_ff;
   assign sts.b_zero      = (b_ff == 64'd0);
   assign sts.e_zero      = (e_ff == 64'd0);
   assign sts.e_lsb       = e_ff[0];
   assign sts.x_one       = (x_ff == 64'd1);
   assign sts.x_nm1       = (x_ff == n_m1);
   assign sts.sq_end      = (sq_ff >= s_ff);
   assign sts.base_last   = (bidx_ff == 3'(NumBase - 1));

endmodule
`default_nettype wire

// ===== sv/mrpt_ctrl.sv =====
// Controller: sequences trial division, base reduction, exponentiation and
// squaring; owns the handshakes and the result register. Depends on mrpt_pkg.
`default_nettype none
module mrpt_ctrl
   import mrpt_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_flag,
   input  wire status_type sts,
   output cmd_type         cmd
);

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b000000000001,
      ST_TRIAL     = 12'b000000000010,
      ST_TRIAL_CHK = 12'b000000000100,
      ST_BASE      = 12'b000000001000,
      ST_BASE_CHK  = 12'b000000010000,
      ST_POW       = 12'b000000100000,
      ST_POW_SQ    = 12'b000001000000,
      ST_CHECK     = 12'b000010000000,
      ST_SQR       = 12'b000100000000,
      ST_SQR_CHK   = 12'b001000000000,
      ST_WAIT      = 12'b010000000000,
      ST_DONE      = 12'b100000000000
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;
   logic      flag_ff, flag_in;
   logic      vld_ff, vld_in;
   logic      out_ff, out_in;
   logic      pass, fail;

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      flag_in   = flag_ff;
      cmd       = '0;
      cmd.mul_op = MUL_RED;
      req_ready = 1'b0;
      pass      = 1'b0;
      fail      = 1'b0;
      vld_in    = vld_ff && !rsp_ready;
      out_in    = out_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_TRIAL;
            end
         end
         ST_TRIAL: begin
            if (sts.n_invalid) begin
               flag_in  = 1'b0;
               state_in = ST_DONE;
            end else begin
               cmd.trial_step = 1'b1;
               if (sts.trial_last) state_in = ST_TRIAL_CHK;
            end
         end
         ST_TRIAL_CHK: begin
            if (sts.small_hit) begin
               flag_in  = sts.small_prime;
               state_in = ST_DONE;
            end else begin
               state_in = ST_BASE;
            end
         end
         ST_BASE: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MUL_RED;
            ret_in        = ST_BASE_CHK;
            state_in      = ST_WAIT;
         end
         ST_BASE_CHK: begin
            if (sts.b_zero) begin
               pass = 1'b1;
            end else begin
               cmd.init_pow = 1'b1;
               state_in     = ST_POW;
            end
         end
         ST_POW: begin
            if (sts.e_zero) begin
               state_in = ST_CHECK;
            end else if (sts.e_lsb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_XB;
               ret_in        = ST_POW_SQ;
               state_in      = ST_WAIT;
            end else begin
               state_in = ST_POW_SQ;
            end
         end
         ST_POW_SQ: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MUL_BB;
            cmd.shift_e   = 1'b1;
            ret_in        = ST_POW;
            state_in      = ST_WAIT;
         end
         ST_CHECK: begin
            if (sts.x_one || sts.x_nm1) begin
               pass = 1'b1;
            end else begin
               cmd.sq_init = 1'b1;
               state_in    = ST_SQR;
            end
         end
         ST_SQR: begin
            if (sts.sq_end) begin
               fail = 1'b1;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_XX;
               ret_in        = ST_SQR_CHK;
               state_in      = ST_WAIT;
            end
         end
         ST_SQR_CHK: begin
            if (sts.x_nm1) begin
               pass = 1'b1;
            end else begin
               cmd.sq_inc = 1'b1;
               state_in   = ST_SQR;
            end
         end
         ST_WAIT: begin
            if (!sts.mul_busy) state_in = ret_ff;
         end
         ST_DONE: begin
            if (!vld_ff || rsp_ready) begin
               vld_in   = 1'b1;
               out_in   = flag_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (pass) begin
         if (sts.base_last) begin
            flag_in  = 1'b1;
            state_in = ST_DONE;
         end else begin
            cmd.base_inc = 1'b1;
            state_in     = ST_BASE;
         end
      end
      if (fail) begin
         flag_in  = 1'b0;
         state_in = ST_DONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         vld_ff   <= vld_in;
      end
      flag_ff <= flag_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = vld_ff;
   assign rsp_flag  = out_ff;

endmodule
`default_nettype wire

// ===== dv/miller_rabin_primality_test_tb.sv =====
// Self-checking testbench for miller_rabin_primality_test: directed table, then random
// numbers (mostly odd primes, prime products, pseudoprime-like values), checked against
// a local primality predictor. Uses mrpt_pkg, mrpt_req_if, mrpt_rsp_if and the DUT.
`timescale 1ns / 100ps
`default_nettype none
module miller_rabin_primality_test_tb
   import mrpt_pkg::*;
();

   logic clock = 1'b0;
   logic reset = 1'b1;

   mrpt_req_if req ();
   mrpt_rsp_if rsp ();

   miller_rabin_primality_test u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected prime flags, oldest first
   logic flag_queue[$];
   int   error_count = 0;
   bit   stim_done   = 1'b0;

   // receiver hold-off, counted in its own process
   bit   hold_rsp   = 1'b0;
   bit   calm_phase = 1'b0;   // stretch with no idling on either side

   // ---------------------------------------------------------------------
   // Predictor: exact modular arithmetic on 128-bit products.
   // ---------------------------------------------------------------------
   function automatic logic [63:0] mulmod(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] m);
      logic [127:0] p;
      p = a * b;
      return 64'(p % m);
   endfunction

   function automatic logic [63:0] powmod(input logic [63:0] b, input logic [63:0] e,
                                          input logic [63:0] m);
      logic [63:0] r;
      r = 64'd1 % m;
      b = b % m;
      while (e != 64'd0) begin
         if (e[0]) r = mulmod(r, b, m);
         b = mulmod(b, b, m);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic logic primality_of(input logic signed [63:0] number);
      logic [63:0] n, d, x;
      int          s;
      bit          ok;
      if (number < 2) return 1'b0;
      n = 64'(number);
      for (int i = 0; i < NumSmall; i++) begin
         if (n % 64'(SMALL_PRIMES[i]) == 64'd0) return n == 64'(SMALL_PRIMES[i]);
      end
      d = n - 64'd1;
      s = 0;
      while (!d[0]) begin
         d = d >> 1;
         s++;
      end
      for (int i = 0; i < NumBase; i++) begin
         if (64'(MR_BASES[i]) % n == 64'd0) continue;
         x  = powmod(64'(MR_BASES[i]), d, n);
         ok = (x == 64'd1) || (x == n - 64'd1);
         for (int j = 1; j < s && !ok; j++) begin
            x  = mulmod(x, x, n);
            ok = (x == n - 64'd1);
         end
         if (!ok) return 1'b0;
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Directed table. Flag typed in for the obvious rows; the rest go
   // through the predictor (typed = 0 means "use predictor").
   // ---------------------------------------------------------------------
   typedef struct {
      logic signed [63:0] number;
      bit                 typed;
      logic               flag;
   } directed_row_type;

   localparam int NumDirected = 22;
   directed_row_type directed_table[NumDirected] = '{
      '{64'sh8000_0000_0000_0000, 1, 1'b0},  // most negative
      '{-64'sd7,                  1, 1'b0},  // negative prime magnitude
      '{-64'sd1,                  1, 1'b0},  // all ones
      '{64'sd0,                   1, 1'b0},
      '{64'sd1,                   1, 1'b0},
      '{64'sd2,                   1, 1'b1},  // smallest prime
      '{64'sd37,                  1, 1'b1},  // largest trial prime
      '{64'sd4,                   1, 1'b0},  // divisible by a trial prime
      '{64'sd1369,                1, 1'b0},  // 37 squared
      '{64'sd41,                  1, 1'b1},  // first prime past trial division
      '{64'sd1681,                1, 1'b0},  // 41 squared
      '{64'sd3215031751,          1, 1'b0},  // strong pseudoprime to 2,3,5,7
      '{64'sd325,                 1, 1'b0},  // base equal to n (but divisible by 5)
      '{64'sd450775,              1, 1'b0},
      '{64'sd1795265022,          1, 1'b0},  // even
      '{64'sd2147483647,          1, 1'b1},  // 2^31-1
      '{64'sd4294967291,          0, 1'b0},
      '{64'sd18446744073709551557 >>> 1, 0, 1'b0},
      '{64'sh7FFF_FFFF_FFFF_FFFF, 1, 1'b0},  // largest positive, = 7^2*73*...
      '{64'sh7FFF_FFFF_FFFF_FFE7, 1, 1'b1},  // 2^63-25, largest 63-bit prime
      '{64'sd1000000007,          1, 1'b1},
      '{64'sd3825123056546413051, 1, 1'b0}   // pseudoprime to bases up to 23
   };

   // ---------------------------------------------------------------------
   // Request driver. valid stays up after a request is taken until the
   // next request or an idle cycle replaces it.
   // ---------------------------------------------------------------------
   task automatic send_number(input logic signed [63:0] number, input bit typed,
                              input logic flag);
      logic predicted;
      while (!calm_phase && $urandom_range(99, 0) < 37) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      predicted = primality_of(number);
      if (typed && predicted !== flag) begin
         $error("directed row disagrees: number=%0d table=%0b predicted=%0b",
                number, flag, predicted);
         error_count++;
      end
      req.valid  <= 1'b1;
      req.number <= number;
      do @(posedge clock); while (!req.ready);
      flag_queue.insert(flag_queue.size(), typed ? flag : predicted);
   endtask

   // Random odd number with n bits, forced below 2^63.
   function automatic logic signed [63:0] random_odd(input int bits);
      logic [63:0] v;
      v = {$urandom, $urandom};
      if (bits < 64) v = v & ((64'd1 << bits) - 64'd1);
      v[bits-1] = 1'b1;
      v[0]      = 1'b1;
      v[63]     = 1'b0;
      return v;
   endfunction

   // Next prime at or above a random start; keeps the run mostly on deep paths.
   function automatic logic signed [63:0] random_prime(input int bits);
      logic signed [63:0] v;
      v = random_odd(bits);
      while (!primality_of(v) && v < 64'sh7FFF_FFFF_FFFF_FF00) v += 2;
      return v;
   endfunction

   initial begin
      logic signed [63:0] number;
      logic [31:0]        p, q;
      int                 kind;
      req.valid  <= 1'b0;
      req.number <= '0;
      rsp.ready  <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_table[i])
         send_number(directed_table[i].number, directed_table[i].typed,
                     directed_table[i].flag);

      // sender pause until everything outstanding has arrived
      req.valid <= 1'b0;
      while (flag_queue.size() != 0) @(posedge clock);

      for (int i = 0; i < 100; i++) begin
         calm_phase = (i >= 40 && i < 55);
         if (i == 70) hold_rsp = 1'b1;
         kind = $urandom_range(9, 0);
         case (kind) inside
            [0:2]: number = random_prime($urandom_range(63, 6));
            [3:4]: begin  // product of two primes, often hard composites
               p = 32'(random_prime($urandom_range(31, 6)));
               q = 32'(random_prime($urandom_range(31, 6)));
               number = $signed(64'(p) * 64'(q));
            end
            5: number = random_odd($urandom_range(63, 2));
            6: number = $signed({$urandom, $urandom});   // full range, negatives too
            7: number = 64'($urandom_range(200, 0));
            8: number = 64'(directed_table[$urandom_range(NumDirected-1, 0)].number)
                        + $signed(64'($urandom_range(4, 0))) - 2;
            default: number = random_prime(63);
         endcase
         send_number(number, 1'b0, 1'b0);
      end
      req.valid  <= 1'b0;
      calm_phase = 1'b0;
      stim_done  = 1'b1;
   end

   // Receiver: random stalls, one long hold-off while requests keep coming.
   initial begin
      int hold_cycles;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            hold_rsp    = 1'b0;
            hold_cycles = 0;
            rsp.ready <= 1'b0;
            while (hold_cycles < 300000) begin
               @(posedge clock);
               hold_cycles++;
            end
         end
         rsp.ready <= calm_phase || ($urandom_range(99, 0) >= 37);
      end
   end

   // Result checker
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (flag_queue.size() == 0) begin
            $error("unexpected response: prime_flag=%0b", rsp.prime_flag);
            error_count++;
         end else begin
            logic expected_flag;
            expected_flag = flag_queue.pop_front();
            if (rsp.prime_flag !== expected_flag) begin
               $error("prime_flag mismatch: expected %0b, actual %0b",
                      expected_flag, rsp.prime_flag);
               error_count++;
            end
         end
      end
   end

   // End of run
   initial begin
      wait (stim_done);
      while (flag_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog: budget for all 122 items plus stalls, taken several times over
   initial begin
      #400_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
